[rtl/core/cscan_disk_scheduler_macros.svh]
// Assertion macros shared by the scheduler checker.
`ifndef CSCAN_DISK_SCHEDULER_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSCAN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define CSCAN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

[rtl/core/cscan_pkg.sv]
// Shared constants and types of the C-SCAN scheduler.
package cscan_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int CYL_BITS     = 12;
	localparam int MOVE_BITS    = CYL_BITS + 1;
	localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_HEAD = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP  = CFG_IDX_BITS'(1);

	localparam logic [CYL_BITS-1:0] HEAD_RESET = CYL_BITS'(0);
	localparam logic [CYL_BITS-1:0] TOP_RESET  = CYL_BITS'(1000 % (1 << CYL_BITS));

	// Operation applied to every cell of the chain at once.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_ROTATE
	} chain_op_t;

	typedef struct packed {
		chain_op_t           op;
		logic [CYL_BITS-1:0] value;
		logic [CYL_BITS-1:0] front;
	} chain_ctrl_t;

	typedef struct packed {
		logic                valid;
		logic [CYL_BITS-1:0] cyl;
	} slot_t;

endpackage

[rtl/core/cscan_if.sv]
// Request and result channel interfaces of the C-SCAN scheduler.
interface cscan_req_if;
	import cscan_pkg::*;
	logic                valid;
	logic                ready;
	logic [CYL_BITS-1:0] cylinder;
	logic                last_request;

	modport source (output valid, output cylinder, output last_request, input ready);
	modport sink   (input valid, input cylinder, input last_request, output ready);
endinterface

interface cscan_res_if;
	import cscan_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CYL_BITS-1:0]  served_cylinder;
	logic                 end_of_run;
	logic [MOVE_BITS-1:0] total_movement;

	modport source (output valid, output served_cylinder, output end_of_run,
		output total_movement, input ready);
	modport sink   (input valid, input served_cylinder, input end_of_run,
		input total_movement, output ready);
endinterface

[rtl/core/cscan_disk_scheduler.sv]
// Top level of the C-SCAN disk scheduler.
//
// Requests arrive on the req channel, one transfer per cycle while the block
// is collecting a batch. Each accepted cylinder at or below top_cylinder is
// inserted into a chain of cells kept in descending order; a request above
// top_cylinder, or one that arrives when the chain is full, is dropped. The
// transfer with last_request set is itself a request and closes the batch.
// After the closing transfer the chain rotates the requests above the head to
// its tail, one cell step per cycle. The schedule then leaves on the res
// channel at one result per cycle while the receiver accepts them: the head
// position, the requests at or below the head, top_cylinder as the wrap
// marker, then the requests above the head. The last result carries
// end_of_run and the total movement. req.ready is low from the closing
// transfer until the last result has entered the output register.
// A stalled receiver holds the output register and freezes the emission.
// Reset empties the chain, sets head_position to 0 and top_cylinder to 1000.
// Configuration writes are taken at any cycle with cfg_we high; writes to an
// index beyond the register list are ignored.
module cscan_disk_scheduler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	cscan_req_if.sink                            req,
	cscan_res_if.source                          res,
	input  logic                                 cfg_we,
	input  logic [cscan_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cscan_pkg::CYL_BITS-1:0]       cfg_wdata
);
	import cscan_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROTATE,
		S_HEAD,
		S_LOW,
		S_TOP,
		S_HIGH
	} state_t;

	state_t               state_q;
	logic [CYL_BITS-1:0]  head_q;
	logic [CYL_BITS-1:0]  top_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  rot_q;
	logic [CNT_BITS-1:0]  left_q;
	logic [CYL_BITS-1:0]  fin_q;

	logic                 res_valid_q;
	logic [CYL_BITS-1:0]  res_cyl_q;
	logic                 res_end_q;
	logic [MOVE_BITS-1:0] res_move_q;

	chain_ctrl_t          ctrl;
	slot_t                front;
	logic                 req_fire;
	logic                 store_ok;
	logic                 rotate_ok;
	logic                 load;
	logic [MOVE_BITS-1:0] movement;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RESET;
			top_q  <= TOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEAD: head_q <= cfg_wdata;
				REG_TOP:  top_q  <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && (state_q == S_IDLE);
	assign store_ok  = (req.cylinder <= top_q) && (count_q < CNT_BITS'(MAX_REQUESTS));

	// The front cell moves to the tail while it still lies above the head; the
	// rotation count bounds the loop when every request lies above the head.
	assign rotate_ok = (rot_q != count_q) && front.valid && (front.cyl > head_q);

	// The output register takes a new result when it is empty or being drained.
	assign load = !res_valid_q || res.ready;

	// A top lowered in the middle of a batch can leave the final position above
	// head plus top; the difference then wraps at the width of the field.
	assign movement = MOVE_BITS'(head_q) + MOVE_BITS'(top_q) - MOVE_BITS'(fin_q);

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.value = req.cylinder;
		ctrl.front = front.cyl;
		case (state_q)
			S_IDLE:   if (req_fire && store_ok) ctrl.op = OP_INSERT;
			S_ROTATE: if (rotate_ok) ctrl.op = OP_ROTATE;
			S_LOW:    if (load) ctrl.op = OP_POP;
			S_HIGH:   if (load) ctrl.op = OP_POP;
			default:  ctrl.op = OP_HOLD;
		endcase
	end

	cscan_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.front  (front)
	);

	// Sequencer with the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rot_q       <= '0;
			left_q      <= '0;
			fin_q       <= '0;
			res_valid_q <= 1'b0;
			res_cyl_q   <= '0;
			res_end_q   <= 1'b0;
			res_move_q  <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (store_ok) begin
							count_q <= count_q + CNT_BITS'(1);
						end
						if (req.last_request) begin
							state_q <= S_ROTATE;
							rot_q   <= '0;
							fin_q   <= top_q;
						end
					end
				end
				S_ROTATE: begin
					if (rotate_ok) begin
						rot_q <= rot_q + CNT_BITS'(1);
						fin_q <= front.cyl;
					end else begin
						left_q  <= count_q - rot_q;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (load) begin
						res_valid_q <= 1'b1;
						res_cyl_q   <= head_q;
						res_end_q   <= 1'b0;
						res_move_q  <= '0;
						state_q     <= (left_q != '0) ? S_LOW : S_TOP;
					end
				end
				S_LOW: begin
					if (load) begin
						res_valid_q <= 1'b1;
						res_cyl_q   <= front.cyl;
						res_end_q   <= 1'b0;
						res_move_q  <= '0;
						left_q      <= left_q - CNT_BITS'(1);
						if (left_q == CNT_BITS'(1)) begin
							state_q <= S_TOP;
						end
					end
				end
				S_TOP: begin
					if (load) begin
						res_valid_q <= 1'b1;
						res_cyl_q   <= top_q;
						res_end_q   <= (rot_q == '0);
						res_move_q  <= (rot_q == '0) ? movement : '0;
						left_q      <= rot_q;
						if (rot_q == '0) begin
							state_q <= S_IDLE;
							count_q <= '0;
						end else begin
							state_q <= S_HIGH;
						end
					end
				end
				S_HIGH: begin
					if (load) begin
						res_valid_q <= 1'b1;
						res_cyl_q   <= front.cyl;
						res_end_q   <= (left_q == CNT_BITS'(1));
						res_move_q  <= (left_q == CNT_BITS'(1)) ? movement : '0;
						left_q      <= left_q - CNT_BITS'(1);
						if (left_q == CNT_BITS'(1)) begin
							state_q <= S_IDLE;
							count_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid           = res_valid_q;
	assign res.served_cylinder = res_cyl_q;
	assign res.end_of_run      = res_end_q;
	assign res.total_movement  = res_move_q;

endmodule

[rtl/core/cscan_cell.sv]
// One slot of the sorted request chain.
module cscan_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cscan_pkg::chain_ctrl_t ctrl,
	input  cscan_pkg::slot_t       left,
	input  logic                   left_keep,
	input  cscan_pkg::slot_t       right,
	output cscan_pkg::slot_t       slot,
	output logic                   keep
);
	import cscan_pkg::*;

	logic                valid_q;
	logic [CYL_BITS-1:0] cyl_q;
	slot_t               nxt;

	// A cell keeps its value on insert when it holds something not smaller.
	assign keep = valid_q && (cyl_q >= ctrl.value);
	assign slot = '{valid: valid_q, cyl: cyl_q};

	always_comb begin
		nxt = slot;
		case (ctrl.op)
			OP_INSERT: begin
				if (keep) begin
					nxt = slot;
				end else if (left_keep) begin
					nxt = '{valid: 1'b1, cyl: ctrl.value};
				end else begin
					nxt = left;
				end
			end
			OP_POP: nxt = right;
			OP_ROTATE: begin
				if (right.valid) begin
					nxt = right;
				end else if (valid_q) begin
					nxt = '{valid: 1'b1, cyl: ctrl.front};
				end else begin
					nxt = slot;
				end
			end
			default: nxt = slot;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		cyl_q <= nxt.cyl;
	end

endmodule

[rtl/core/cscan_chain.sv]
// Row of cells that keeps requests in descending order.
module cscan_chain (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cscan_pkg::chain_ctrl_t ctrl,
	output cscan_pkg::slot_t       front
);
	import cscan_pkg::*;

	slot_t slots [MAX_REQUESTS];
	logic  keeps [MAX_REQUESTS];

	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		slot_t left_s;
		slot_t right_s;
		logic  left_k;

		if (i == 0) begin : g_first
			assign left_s = '0;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_s = slots[i-1];
			assign left_k = keeps[i-1];
		end

		if (i == MAX_REQUESTS - 1) begin : g_last
			assign right_s = '0;
		end else begin : g_inner
			assign right_s = slots[i+1];
		end

		cscan_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left      (left_s),
			.left_keep (left_k),
			.right     (right_s),
			.slot      (slots[i]),
			.keep      (keeps[i])
		);
	end

	assign front = slots[0];

endmodule

[rtl/core/cscan_checker.sv]
// Port-level checks of the C-SCAN scheduler and their binding.
`include "cscan_disk_scheduler_macros.svh"

module cscan_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                req_last,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic [cscan_pkg::CYL_BITS-1:0]      res_cyl,
	input logic                                res_end,
	input logic [cscan_pkg::MOVE_BITS-1:0]     res_move
);
	import cscan_pkg::*;

	// A stalled result keeps its contents.
	`CSCAN_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_cyl) && $stable(res_end) && $stable(res_move))

	// Movement is reported only on the final result.
	`CSCAN_ASSERT_IMP(a_move_zero, clk, arst_n, res_valid && !res_end, res_move == '0)

	// Closing a batch stops request intake while the schedule is produced.
	`CSCAN_ASSERT_NXT(a_busy_after_close, clk, arst_n, req_valid && req_ready && req_last, !req_ready)

endmodule

bind cscan_disk_scheduler cscan_checker u_cscan_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_last  (req.last_request),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_cyl   (res.served_cylinder),
	.res_end   (res.end_of_run),
	.res_move  (res.total_movement)
);

[bench/cscan_schedule_checker.sv]
// Scoreboard for the C-SCAN scheduler: predicts each schedule and checks the result channel.
module cscan_schedule_checker
	import cscan_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	cscan_req_if                    req,
	cscan_res_if                    res,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CYL_BITS-1:0]     cfg_wdata,
	output int                      fail_count,
	output int                      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CYL_BITS-1:0]  cyl;
		logic                 end_of_run;
		logic [MOVE_BITS-1:0] movement;
	} sched_entry_t;

	logic [CYL_BITS-1:0] head_reg;
	logic [CYL_BITS-1:0] top_reg;
	logic [CYL_BITS-1:0] batch_cyls[$];
	sched_entry_t        schedule_q[$];

	initial fail_count = 0;

	// Store or drop one request; on the closing one, queue the whole service order.
	task automatic take_request(input logic [CYL_BITS-1:0] cyl, input logic closing);
		logic [CYL_BITS-1:0] order[$];
		sched_entry_t        plan[$];
		logic [CYL_BITS-1:0] final_pos;
		int                  last;
		if (cyl <= top_reg && batch_cyls.size() < MAX_REQUESTS)
			batch_cyls.push_back(cyl);
		if (!closing)
			return;
		order = batch_cyls;
		order.rsort();
		plan.push_back('{head_reg, 1'b0, '0});
		foreach (order[i])
			if (order[i] <= head_reg)
				plan.push_back('{order[i], 1'b0, '0});
		plan.push_back('{top_reg, 1'b0, '0});
		final_pos = top_reg;
		foreach (order[i])
			if (order[i] > head_reg) begin
				plan.push_back('{order[i], 1'b0, '0});
				final_pos = order[i];
			end
		last = plan.size() - 1;
		plan[last].end_of_run = 1'b1;
		plan[last].movement = {1'b0, head_reg} + {1'b0, top_reg} - {1'b0, final_pos};
		foreach (plan[i])
			schedule_q.push_back(plan[i]);
		batch_cyls.delete();
	endtask

	task automatic check_result(input sched_entry_t got);
		sched_entry_t want;
		if (schedule_q.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result: cyl %0d end %0b move %0d",
					got.cyl, got.end_of_run, got.movement);
			fail_count++;
			return;
		end
		want = schedule_q.pop_front();
		if (got.cyl !== want.cyl || got.end_of_run !== want.end_of_run ||
			got.movement !== want.movement) begin
			if (fail_count < 10)
				$display("mismatch: expected cyl %0d end %0b move %0d, got cyl %0d end %0b move %0d",
					want.cyl, want.end_of_run, want.movement,
					got.cyl, got.end_of_run, got.movement);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_reg <= HEAD_RESET;
			top_reg <= TOP_RESET;
			batch_cyls.delete();
			schedule_q.delete();
			outstanding <= 0;
		end else begin
			if (res.valid && res.ready)
				check_result('{res.served_cylinder, res.end_of_run, res.total_movement});
			// The drop test sees the registers as they stand before a write at this edge.
			if (req.valid && req.ready)
				take_request(req.cylinder, req.last_request);
			if (cfg_we) begin
				if (cfg_index == REG_HEAD)
					head_reg <= cfg_wdata;
				else if (cfg_index == REG_TOP)
					top_reg <= cfg_wdata;
			end
			outstanding <= schedule_q.size();
		end
	end

endmodule

[bench/tb_top.sv]
// Top of the C-SCAN scheduler bench: clock, reset, stimulus, receiver and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cscan_pkg::*;

	// Cycles left after the last result before the registers are touched. The
	// block rotates up to one cell step per stored request before emitting.
	localparam int SETTLE_CYCLES    = 48;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int RANDOM_ITEMS     = 110;

	// An index past the register list; writes to it must leave the block alone.
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(2);

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CYL_BITS-1:0]     cfg_wdata;
	int                      fail_count;
	int                      outstanding;
	int                      idle_cycles = 0;
	bit                      send_steady;
	bit                      long_hold;
	logic [CYL_BITS-1:0]     head_now;
	logic [CYL_BITS-1:0]     top_now;

	cscan_req_if req_ch();
	cscan_res_if res_ch();

	cscan_disk_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cscan_schedule_checker sched_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int gap_len(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one request and return at the edge where it is transferred. The
	// valid line stays high afterwards so that a back-to-back request needs no
	// second assignment in the same time step.
	task automatic send_request(input logic [CYL_BITS-1:0] cyl, input logic closing);
		int gap;
		gap = gap_len(send_steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cylinder <= cyl;
		req_ch.last_request <= closing;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Stop offering, wait for every predicted result to arrive, then let the
	// block finish any rotation or insertion still going on inside it.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the head, then the top, then one ignored index, on consecutive edges.
	task automatic configure(input logic [CYL_BITS-1:0] head, input logic [CYL_BITS-1:0] top);
		cfg_we <= 1'b1;
		cfg_index <= REG_HEAD;
		cfg_wdata <= head;
		@(posedge clk);
		cfg_index <= REG_TOP;
		cfg_wdata <= top;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= CYL_BITS'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		head_now = head;
		top_now = top;
	endtask

	function automatic logic [CYL_BITS-1:0] pick_top();
		case ($urandom_range(0, 5))
			0: return CYL_BITS'(1);
			1: return {CYL_BITS{1'b1}};
			default: return CYL_BITS'($urandom_range(1, (1 << CYL_BITS) - 1));
		endcase
	endfunction

	// Mostly a head within the disk; sometimes at an end or even above the top.
	function automatic logic [CYL_BITS-1:0] pick_head(input logic [CYL_BITS-1:0] top);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return top;
			2: return CYL_BITS'($urandom());
			default: return CYL_BITS'($urandom_range(0, top));
		endcase
	endfunction

	// Receiver: random stalls, long stretches of steady acceptance, and one
	// long hold-off on request so that emission freezes while new requests
	// keep being offered and the block has to stall its input.
	initial begin
		int stall_left;
		int run_left;
		res_ch.ready <= 1'b0;
		stall_left = 0;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(0, 6);
					stall_left = gap_len(1'b0);
				end
			end
		end
	end

	// Watchdog: the run ends if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                  items;
		int                  batch;
		int                  size;
		logic [CYL_BITS-1:0] cyl;
		logic [CYL_BITS-1:0] new_top;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cylinder <= '0;
		req_ch.last_request <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_HEAD;
		cfg_wdata <= '0;
		head_now = HEAD_RESET;
		top_now = TOP_RESET;
		send_steady = 1'b0;
		long_hold = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers (head 0, top 1000). A request equal to the head is
		// served in the first sweep; requests above the top are dropped.
		send_request(CYL_BITS'(0), 1'b0);
		send_request(CYL_BITS'(1000), 1'b0);
		send_request(CYL_BITS'(1001), 1'b0);
		send_request({CYL_BITS{1'b1}}, 1'b0);
		send_request(CYL_BITS'(500), 1'b1);

		// Both registers at their maximum: nothing lies above the head, so the
		// final position is the top and the alternating-bit patterns all go first.
		quiesce();
		configure({CYL_BITS{1'b1}}, {CYL_BITS{1'b1}});
		send_request({CYL_BITS{1'b1}}, 1'b0);
		send_request(CYL_BITS'(0), 1'b0);
		send_request(CYL_BITS'('hAAA), 1'b0);
		send_request(CYL_BITS'('h555), 1'b1);

		// Head above the smallest top: the movement equals the head position.
		quiesce();
		configure(CYL_BITS'(3000), CYL_BITS'(1));
		send_request(CYL_BITS'(1), 1'b0);
		send_request(CYL_BITS'(2), 1'b0);
		send_request(CYL_BITS'(0), 1'b1);

		// A batch of one closing request, lying above the head.
		quiesce();
		configure('0, {CYL_BITS{1'b1}});
		send_request({CYL_BITS{1'b1}}, 1'b1);

		// The closing request itself is dropped, leaving an empty batch.
		quiesce();
		configure('0, CYL_BITS'(1));
		send_request(CYL_BITS'(5), 1'b1);

		// Top lowered in the middle of a batch: earlier requests stay stored,
		// later ones are tested against the new top, and emission uses it.
		quiesce();
		configure(CYL_BITS'(100), CYL_BITS'(2000));
		send_request(CYL_BITS'(1500), 1'b0);
		send_request(CYL_BITS'(150), 1'b0);
		quiesce();
		configure(CYL_BITS'(100), CYL_BITS'(1000));
		send_request(CYL_BITS'(1500), 1'b0);
		send_request(CYL_BITS'(50), 1'b1);

		// Random batches. The first one overflows the store. Batch two ends
		// with the receiver's long hold-off and batch three follows without a
		// pause, so its requests pile up against a stalled input.
		items = 0;
		batch = 0;
		while (items < RANDOM_ITEMS) begin
			if (batch == 0)
				size = MAX_REQUESTS + 4;
			else if (batch == 2)
				size = 24;
			else if ($urandom_range(0, 9) < 7)
				size = $urandom_range(1, 6);
			else if ($urandom_range(0, 3) != 0)
				size = $urandom_range(7, 16);
			else
				size = $urandom_range(28, 40);
			if (batch == 0 || (batch != 3 && $urandom_range(0, 2) == 0)) begin
				quiesce();
				new_top = pick_top();
				configure(pick_head(new_top), new_top);
			end
			send_steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < size; k++) begin
				if ($urandom_range(0, 9) < 7)
					cyl = CYL_BITS'($urandom_range(0, top_now));
				else
					cyl = CYL_BITS'($urandom());
				if ($urandom_range(0, 15) == 0)
					cyl = head_now;
				if (batch == 2 && k == size - 1)
					long_hold = 1'b1;
				send_request(cyl, k == size - 1);
			end
			items += size;
			batch++;
		end

		quiesce();
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
